// ===== rtl/fwa_pkg.sv =====
// ----------------------------------------------------------------------------
// fwa_pkg
// Types, codes and helper functions shared by the front wall align sequencer.
// ----------------------------------------------------------------------------
package fwa_pkg;

   // range readings at or above this are treated as no echo
   localparam logic [9:0] RANGE_LIMIT      = 10'd300;
   localparam logic [7:0] MEASURE_WAIT_MS  = 8'd80;
   localparam logic [7:0] CONFIRM_WAIT_MS  = 8'd50;
   localparam logic [7:0] APPROACH_WAIT_MS = 8'd10;
   localparam logic [7:0] COUNT_MAX        = 8'd255;

   // drive commands
   typedef logic [1:0] motion_type;
   localparam motion_type MOTION_STOP = 2'd0;
   localparam motion_type MOTION_FWD  = 2'd1;
   localparam motion_type MOTION_CW   = 2'd2;
   localparam motion_type MOTION_CCW  = 2'd3;

   // phase codes reported on the result beat
   typedef logic [3:0] phase_type;
   localparam phase_type PH_INIT      = 4'd0;
   localparam phase_type PH_MEAS_L    = 4'd1;
   localparam phase_type PH_MEAS_R    = 4'd2;
   localparam phase_type PH_CHECK     = 4'd3;
   localparam phase_type PH_TURN_WAIT = 4'd6;
   localparam phase_type PH_CONF_L    = 4'd7;
   localparam phase_type PH_CONF_R    = 4'd8;
   localparam phase_type PH_APPROACH  = 4'd9;
   localparam phase_type PH_APP_L     = 4'd10;
   localparam phase_type PH_APP_R     = 4'd11;
   localparam phase_type PH_DONE      = 4'd12;

   // register indexes on the csr port
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_EQUAL_TOL    = 3'd0;
   localparam csr_index_type CSR_DIST_TOL     = 3'd1;
   localparam csr_index_type CSR_TARGET       = 3'd2;
   localparam csr_index_type CSR_CONFIRM_LIM  = 3'd3;
   localparam csr_index_type CSR_INVALID_LIM  = 3'd4;
   localparam csr_index_type CSR_INVALID_TMO  = 3'd5;
   localparam csr_index_type CSR_TURN_PULSE   = 3'd6;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_ALIGN = 3'b010,
      MODE_DONE  = 3'b100
   } mode_type;

   typedef enum logic [10:0] {
      ST_INIT      = 11'b000_0000_0001,
      ST_MEAS_L    = 11'b000_0000_0010,
      ST_MEAS_R    = 11'b000_0000_0100,
      ST_CHECK     = 11'b000_0000_1000,
      ST_TURN_WAIT = 11'b000_0001_0000,
      ST_CONF_L    = 11'b000_0010_0000,
      ST_CONF_R    = 11'b000_0100_0000,
      ST_APPROACH  = 11'b000_1000_0000,
      ST_APP_L     = 11'b001_0000_0000,
      ST_APP_R     = 11'b010_0000_0000,
      ST_DONE      = 11'b100_0000_0000
   } step_type;

   typedef struct packed {
      logic [7:0]  equal_tol_cm;
      logic [7:0]  dist_tol_cm;
      logic [8:0]  target_cm;
      logic [7:0]  confirm_limit;
      logic [7:0]  invalid_limit;
      logic [15:0] invalid_tmo_ms;
      logic [15:0] turn_pulse_ms;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      step_type    step;
      logic [31:0] clock_ms;
      logic [31:0] mark_ms;
      logic [31:0] bad_start_ms;
      logic [9:0]  held_left;
      logic [9:0]  held_right;
      logic [7:0]  confirm_count;
      logic [7:0]  bad_count;
      motion_type  drive;
      logic        skip_flag;
   } seq_state_type;

   // zero or out of range means no usable echo
   function automatic logic range_bad(input logic [9:0] r);
      range_bad = (r == 10'd0) || (r >= RANGE_LIMIT);
   endfunction

   // left and right agree within the tolerance
   function automatic logic pair_match(input logic [9:0] a, input logic [9:0] b,
                                       input logic [7:0] tol);
      logic [9:0] d;
      d = (a > b) ? (a - b) : (b - a);
      pair_match = d <= {2'b00, tol};
   endfunction

   function automatic phase_type step_code(input step_type s);
      case (s)
         ST_INIT:      step_code = PH_INIT;
         ST_MEAS_L:    step_code = PH_MEAS_L;
         ST_MEAS_R:    step_code = PH_MEAS_R;
         ST_CHECK:     step_code = PH_CHECK;
         ST_TURN_WAIT: step_code = PH_TURN_WAIT;
         ST_CONF_L:    step_code = PH_CONF_L;
         ST_CONF_R:    step_code = PH_CONF_R;
         ST_APPROACH:  step_code = PH_APPROACH;
         ST_APP_L:     step_code = PH_APP_L;
         ST_APP_R:     step_code = PH_APP_R;
         ST_DONE:      step_code = PH_DONE;
         default:      step_code = PH_INIT;
      endcase
   endfunction

endpackage

// ===== rtl/front_wall_align_sequencer.sv =====
// ----------------------------------------------------------------------------
// front_wall_align_sequencer
// Squares a robot up to a front wall from two front range readings: paces
// left and right samples, turns toward the nearer side, confirms the match
// and drives forward to the target distance.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | action, elapsed, left and right range
//  rsp     | out       | rsp_valid/rsp_ready | motion, busy, complete, skipped, phase
//  csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// one result beat for every request beat; rsp_valid rises once the beat has passed
// from the input register through the step logic into the result register
// a new request beat can be taken every cycle while the result slot is free or
// being taken; the sequence state updates as the beat leaves the input register
// rsp_ready low holds the result register and then the input register
// synchronous reset restores the register defaults and the idle sequence
// ----------------------------------------------------------------------------
module front_wall_align_sequencer
   import fwa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_elapsed_ms,
   input  logic [9:0]  req_left_range_cm,
   input  logic [9:0]  req_right_range_cm,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_motion,
   output logic        rsp_busy_res,
   output logic        rsp_complete,
   output logic        rsp_skipped,
   output logic [3:0]  rsp_phase,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type       cfg_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          in_valid_ff;
   logic          in_action_ff;
   logic [7:0]    in_elapsed_ff;
   logic [9:0]    in_left_ff;
   logic [9:0]    in_right_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_motion_ff;
   logic          rsp_busy_ff;
   logic          rsp_complete_ff;
   logic          rsp_skipped_ff;
   logic [3:0]    rsp_phase_ff;
   logic          advance;

   // the input register moves on when the result slot is free or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.equal_tol_cm   <= 8'd2;
         cfg_ff.dist_tol_cm    <= 8'd2;
         cfg_ff.target_cm      <= 9'd15;
         cfg_ff.confirm_limit  <= 8'd3;
         cfg_ff.invalid_limit  <= 8'd5;
         cfg_ff.invalid_tmo_ms <= 16'd2000;
         cfg_ff.turn_pulse_ms  <= 16'd50;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_EQUAL_TOL:   cfg_ff.equal_tol_cm   <= csr_wdata[7:0];
            CSR_DIST_TOL:    cfg_ff.dist_tol_cm    <= csr_wdata[7:0];
            CSR_TARGET:      cfg_ff.target_cm      <= csr_wdata[8:0];
            CSR_CONFIRM_LIM: cfg_ff.confirm_limit  <= csr_wdata[7:0];
            CSR_INVALID_LIM: cfg_ff.invalid_limit  <= csr_wdata[7:0];
            CSR_INVALID_TMO: cfg_ff.invalid_tmo_ms <= csr_wdata;
            CSR_TURN_PULSE:  cfg_ff.turn_pulse_ms  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff  <= req_action;
         in_elapsed_ff <= req_elapsed_ms;
         in_left_ff    <= req_left_range_cm;
         in_right_ff   <= req_right_range_cm;
      end
   end

   // step logic
   fwa_step u_step (
      .cur            (state_ff),
      .cfg            (cfg_ff),
      .action         (in_action_ff),
      .elapsed_ms     (in_elapsed_ff),
      .left_range_cm  (in_left_ff),
      .right_range_cm (in_right_ff),
      .nxt            (state_in)
   );

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= MODE_IDLE;
         state_ff.step          <= ST_INIT;
         state_ff.clock_ms      <= 32'd0;
         state_ff.mark_ms       <= 32'd0;
         state_ff.bad_start_ms  <= 32'd0;
         state_ff.held_left     <= 10'd0;
         state_ff.held_right    <= 10'd0;
         state_ff.confirm_count <= 8'd0;
         state_ff.bad_count     <= 8'd0;
         state_ff.drive         <= MOTION_STOP;
         state_ff.skip_flag     <= 1'b0;
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (in_valid_ff && advance) begin
         rsp_motion_ff   <= state_in.drive;
         rsp_busy_ff     <= state_in.mode == MODE_ALIGN;
         rsp_complete_ff <= state_in.mode == MODE_DONE;
         rsp_skipped_ff  <= state_in.skip_flag;
         rsp_phase_ff    <= step_code(state_in.step);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_motion   = rsp_motion_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_complete = rsp_complete_ff;
   assign rsp_skipped  = rsp_skipped_ff;
   assign rsp_phase    = rsp_phase_ff;

   // a beat in the input register lands in a free result slot
   a_beat_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> rsp_valid_ff)
      else $error("input beat did not reach the result register");

   // a skipped sequence always reports the done phase
   a_skip_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_skipped_ff |-> rsp_phase_ff == PH_DONE)
      else $error("skipped flag outside the done phase");

   // complete is only reported from the done phase
   a_complete_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_complete_ff |-> rsp_phase_ff == PH_DONE && !rsp_busy_ff)
      else $error("complete reported outside the done phase");

   // the invalid timer origin is clear whenever no invalid reading is pending
   a_bad_start_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.bad_count == 8'd0 |-> state_ff.bad_start_ms == 32'd0)
      else $error("invalid start time held with no invalid count");

endmodule

// ===== rtl/fwa_step.sv =====
// ----------------------------------------------------------------------------
// fwa_step
// Next-state logic of the alignment sequence for one beat: advances the
// millisecond clock, handles a start, or moves the sequence one sub-step.
// ----------------------------------------------------------------------------
module fwa_step
   import fwa_pkg::*;
(
   input  seq_state_type cur,
   input  cfg_type       cfg,
   input  logic          action,
   input  logic [7:0]    elapsed_ms,
   input  logic [9:0]    left_range_cm,
   input  logic [9:0]    right_range_cm,
   output seq_state_type nxt
);

   logic [31:0] clock_new;
   logic [31:0] since_mark;
   logic        wait_measure;
   logic        wait_confirm;
   logic        wait_approach;
   logic        wait_turn;
   logic [31:0] bad_start_eff;
   logic [7:0]  bad_count_inc;
   logic        skip_hit;
   logic        held_bad;
   logic        app_bad;
   logic [7:0]  confirm_inc;
   logic [10:0] range_sum;
   logic [9:0]  stop_limit;

   // shared timing and bookkeeping terms
   assign clock_new     = cur.clock_ms + {24'd0, elapsed_ms};
   assign since_mark    = clock_new - cur.mark_ms;
   assign wait_measure  = since_mark >= {24'd0, MEASURE_WAIT_MS};
   assign wait_confirm  = since_mark >= {24'd0, CONFIRM_WAIT_MS};
   assign wait_approach = since_mark >= {24'd0, APPROACH_WAIT_MS};
   assign wait_turn     = since_mark >= {16'd0, cfg.turn_pulse_ms};

   // invalid reading accounting
   assign bad_start_eff = (cur.bad_count == 8'd0) ? clock_new : cur.bad_start_ms;
   assign bad_count_inc = (cur.bad_count < COUNT_MAX) ? cur.bad_count + 8'd1
                                                      : cur.bad_count;
   assign skip_hit = (bad_count_inc >= cfg.invalid_limit) ||
                     ((clock_new - bad_start_eff) >= {16'd0, cfg.invalid_tmo_ms});
   assign held_bad = range_bad(cur.held_left) || range_bad(cur.held_right);
   assign app_bad  = range_bad(cur.held_left) || range_bad(right_range_cm);

   assign confirm_inc = (cur.confirm_count < COUNT_MAX) ? cur.confirm_count + 8'd1
                                                        : cur.confirm_count;

   // approach stop test on the average range
   assign range_sum  = {1'b0, cur.held_left} + {1'b0, right_range_cm};
   assign stop_limit = {1'b0, cfg.target_cm} + {2'b00, cfg.dist_tol_cm};

   // sequence step
   always_comb begin
      nxt          = cur;
      nxt.clock_ms = clock_new;
      if (action) begin
         nxt.mode          = MODE_ALIGN;
         nxt.step          = ST_INIT;
         nxt.mark_ms       = clock_new;
         nxt.confirm_count = 8'd0;
         nxt.bad_count     = 8'd0;
         nxt.bad_start_ms  = 32'd0;
         nxt.skip_flag     = 1'b0;
      end else if (cur.mode == MODE_ALIGN) begin
         case (cur.step)
            ST_INIT: begin
               nxt.step    = ST_MEAS_L;
               nxt.mark_ms = clock_new;
            end
            ST_MEAS_L: begin
               if (wait_measure) begin
                  nxt.held_left = left_range_cm;
                  nxt.mark_ms   = clock_new;
                  nxt.step      = ST_MEAS_R;
               end
            end
            ST_MEAS_R: begin
               if (wait_measure) begin
                  nxt.held_right = right_range_cm;
                  nxt.mark_ms    = clock_new;
                  nxt.step       = ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (held_bad) begin
                  nxt.drive        = MOTION_STOP;
                  nxt.bad_start_ms = bad_start_eff;
                  nxt.bad_count    = bad_count_inc;
                  if (skip_hit) begin
                     nxt.step      = ST_DONE;
                     nxt.skip_flag = 1'b1;
                  end else begin
                     nxt.step    = ST_MEAS_L;
                     nxt.mark_ms = clock_new;
                  end
               end else begin
                  nxt.bad_count    = 8'd0;
                  nxt.bad_start_ms = 32'd0;
                  nxt.mark_ms      = clock_new;
                  if (pair_match(cur.held_left, cur.held_right, cfg.equal_tol_cm)) begin
                     nxt.confirm_count = 8'd0;
                     nxt.step          = ST_CONF_L;
                  end else begin
                     nxt.drive = (cur.held_left > cur.held_right) ? MOTION_CW : MOTION_CCW;
                     nxt.step  = ST_TURN_WAIT;
                  end
               end
            end
            ST_TURN_WAIT: begin
               if (wait_turn) begin
                  nxt.drive   = MOTION_STOP;
                  nxt.step    = ST_MEAS_L;
                  nxt.mark_ms = clock_new;
               end
            end
            ST_CONF_L: begin
               if (wait_confirm) begin
                  nxt.held_left = left_range_cm;
                  nxt.mark_ms   = clock_new;
                  nxt.step      = ST_CONF_R;
               end
            end
            ST_CONF_R: begin
               if (wait_confirm) begin
                  nxt.held_right = right_range_cm;
                  nxt.mark_ms    = clock_new;
                  if (pair_match(cur.held_left, right_range_cm, cfg.equal_tol_cm)) begin
                     nxt.confirm_count = confirm_inc;
                     if (confirm_inc >= cfg.confirm_limit) begin
                        nxt.drive = MOTION_STOP;
                        nxt.step  = ST_APPROACH;
                     end else begin
                        nxt.step = ST_CONF_L;
                     end
                  end else begin
                     nxt.confirm_count = 8'd0;
                     nxt.step          = ST_MEAS_L;
                  end
               end
            end
            ST_APPROACH: begin
               nxt.drive   = MOTION_FWD;
               nxt.step    = ST_APP_L;
               nxt.mark_ms = clock_new;
            end
            ST_APP_L: begin
               if (wait_approach) begin
                  nxt.held_left = left_range_cm;
                  nxt.mark_ms   = clock_new;
                  nxt.step      = ST_APP_R;
               end
            end
            ST_APP_R: begin
               if (wait_approach) begin
                  nxt.held_right = right_range_cm;
                  nxt.mark_ms    = clock_new;
                  if (app_bad) begin
                     nxt.drive        = MOTION_STOP;
                     nxt.bad_start_ms = bad_start_eff;
                     nxt.bad_count    = bad_count_inc;
                     if (skip_hit) begin
                        nxt.step      = ST_DONE;
                        nxt.skip_flag = 1'b1;
                     end else begin
                        nxt.step = ST_APPROACH;
                     end
                  end else begin
                     nxt.bad_count    = 8'd0;
                     nxt.bad_start_ms = 32'd0;
                     if (range_sum[10:1] <= stop_limit) begin
                        nxt.drive = MOTION_STOP;
                        nxt.step  = ST_DONE;
                     end else begin
                        nxt.step = ST_APP_L;
                     end
                  end
               end
            end
            ST_DONE: begin
               nxt.mode = MODE_DONE;
            end
            default: begin
               nxt = cur;
               nxt.clock_ms = clock_new;
            end
         endcase
      end
   end

endmodule
